// ===== rtl/core/sgvg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sgvg_pkg
// shared constants, types and the stencil schedule of the gradient block
// ----------------------------------------------------------------------------
package sgvg_pkg;

  localparam int MAX_CELLS_X = 16;
  localparam int MAX_CELLS_Y = 16;
  localparam int MAX_CELLS_Z = 16;
  localparam int GHOST       = 1;

  localparam int SX    = MAX_CELLS_X + 2 * GHOST + 1;
  localparam int SY    = MAX_CELLS_Y + 2 * GHOST + 1;
  localparam int SZ    = MAX_CELLS_Z + 2 * GHOST + 1;
  localparam int DEPTH = SX * SY * SZ;
  localparam int AW    = $clog2(DEPTH);

  localparam int NREAD = 30;
  localparam int SW    = $clog2(NREAD + 1);

  localparam logic [1:0] KIND_U = 2'd0;
  localparam logic [1:0] KIND_V = 2'd1;
  localparam logic [1:0] KIND_W = 2'd2;
  localparam logic [1:0] KIND_C = 2'd3;

  localparam logic [2:0] REG_CX = 3'd0;
  localparam logic [2:0] REG_CY = 3'd1;
  localparam logic [2:0] REG_CZ = 3'd2;
  localparam logic [2:0] REG_FL = 3'd3;
  localparam logic [2:0] REG_IX = 3'd4;
  localparam logic [2:0] REG_IY = 3'd5;
  localparam logic [2:0] REG_IZ = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCALE,
    ST_DONE
  } state_t;

  // one stencil read: store, offsets, target entry and sign
  typedef struct packed {
    logic [1:0] st;
    logic [1:0] dx;   // 0:-1 1:0 2:+1
    logic [1:0] dy;
    logic [1:0] dz;
    logic [3:0] ent;
    logic       neg;
  } tap_t;

  // scale parameters per tensor entry
  typedef struct packed {
    logic [1:0] axis;  // 0 x 1 y 2 z
    logic       quarter;
    logic       three_d;
  } ent_t;

  function automatic tap_t mk(input logic [1:0] st, input int dx, input int dy,
                              input int dz, input int ent, input logic neg);
    tap_t t;
    t.st  = st;
    t.dx  = 2'(dx + 1);
    t.dy  = 2'(dy + 1);
    t.dz  = 2'(dz + 1);
    t.ent = 4'(ent);
    t.neg = neg;
    return t;
  endfunction

  function automatic tap_t tap_of(input logic [SW-1:0] i);
    tap_t t;
    t = mk(KIND_U, 0, 0, 0, 0, 1'b0);
    unique case (i)
      SW'(0):  t = mk(KIND_U,  1,  0,  0, 0, 1'b0);
      SW'(1):  t = mk(KIND_U,  0,  0,  0, 0, 1'b1);
      SW'(2):  t = mk(KIND_U,  0,  1,  0, 1, 1'b0);
      SW'(3):  t = mk(KIND_U,  1,  1,  0, 1, 1'b0);
      SW'(4):  t = mk(KIND_U,  0, -1,  0, 1, 1'b1);
      SW'(5):  t = mk(KIND_U,  1, -1,  0, 1, 1'b1);
      SW'(6):  t = mk(KIND_V,  1,  0,  0, 3, 1'b0);
      SW'(7):  t = mk(KIND_V,  1,  1,  0, 3, 1'b0);
      SW'(8):  t = mk(KIND_V, -1,  0,  0, 3, 1'b1);
      SW'(9):  t = mk(KIND_V, -1,  1,  0, 3, 1'b1);
      SW'(10): t = mk(KIND_V,  0,  1,  0, 4, 1'b0);
      SW'(11): t = mk(KIND_V,  0,  0,  0, 4, 1'b1);
      SW'(12): t = mk(KIND_U,  0,  0,  1, 2, 1'b0);
      SW'(13): t = mk(KIND_U,  1,  0,  1, 2, 1'b0);
      SW'(14): t = mk(KIND_U,  0,  0, -1, 2, 1'b1);
      SW'(15): t = mk(KIND_U,  1,  0, -1, 2, 1'b1);
      SW'(16): t = mk(KIND_V,  0,  0,  1, 5, 1'b0);
      SW'(17): t = mk(KIND_V,  0,  1,  1, 5, 1'b0);
      SW'(18): t = mk(KIND_V,  0,  0, -1, 5, 1'b1);
      SW'(19): t = mk(KIND_V,  0,  1, -1, 5, 1'b1);
      SW'(20): t = mk(KIND_W,  1,  0,  0, 6, 1'b0);
      SW'(21): t = mk(KIND_W,  1,  0,  1, 6, 1'b0);
      SW'(22): t = mk(KIND_W, -1,  0,  0, 6, 1'b1);
      SW'(23): t = mk(KIND_W, -1,  0,  1, 6, 1'b1);
      SW'(24): t = mk(KIND_W,  0,  1,  0, 7, 1'b0);
      SW'(25): t = mk(KIND_W,  0,  1,  1, 7, 1'b0);
      SW'(26): t = mk(KIND_W,  0, -1,  0, 7, 1'b1);
      SW'(27): t = mk(KIND_W,  0, -1,  1, 7, 1'b1);
      SW'(28): t = mk(KIND_W,  0,  0,  1, 8, 1'b0);
      SW'(29): t = mk(KIND_W,  0,  0,  0, 8, 1'b1);
      default: t = mk(KIND_U,  0,  0,  0, 0, 1'b0);
    endcase
    return t;
  endfunction

  function automatic ent_t ent_of(input logic [3:0] e);
    ent_t r;
    r = '{axis: 2'd0, quarter: 1'b0, three_d: 1'b0};
    unique case (e)
      4'd0:    r = '{axis: 2'd0, quarter: 1'b0, three_d: 1'b0};
      4'd1:    r = '{axis: 2'd1, quarter: 1'b1, three_d: 1'b0};
      4'd2:    r = '{axis: 2'd2, quarter: 1'b1, three_d: 1'b1};
      4'd3:    r = '{axis: 2'd0, quarter: 1'b1, three_d: 1'b0};
      4'd4:    r = '{axis: 2'd1, quarter: 1'b0, three_d: 1'b0};
      4'd5:    r = '{axis: 2'd2, quarter: 1'b1, three_d: 1'b1};
      4'd6:    r = '{axis: 2'd0, quarter: 1'b1, three_d: 1'b1};
      4'd7:    r = '{axis: 2'd1, quarter: 1'b1, three_d: 1'b1};
      4'd8:    r = '{axis: 2'd2, quarter: 1'b0, three_d: 1'b1};
      default: r = '{axis: 2'd0, quarter: 1'b0, three_d: 1'b0};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sgvg_scale.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sgvg_scale
// multiplies a face difference by a reciprocal spacing, floors and saturates
// ----------------------------------------------------------------------------
module sgvg_scale (
  input  wire logic        clk,
  input  wire logic        go,
  input  wire logic [34:0] diff,
  input  wire logic [31:0] inv,
  input  wire logic        quarter,
  output logic             done,
  output logic [31:0]      res
);
  import sgvg_pkg::*;

  logic        neg_r, quarter_r, v1_r, v2_r;
  logic        neg2_r, quarter2_r;
  logic [33:0] mag_r;
  logic [15:0] ihi_r, ilo_r;
  logic [49:0] a_r, b_r;
  logic [31:0] res_r;

  logic [33:0] mag_c;
  logic [50:0] q_c;
  logic [50:0] quot_c;
  logic        rem_c;
  logic [50:0] fin_c;

  assign mag_c = diff[34] ? 34'(-diff) : diff[33:0];

  // stage 1: magnitude; stage 2: partial products with sign and shift;
  // stage 3: combine
  always_ff @(posedge clk) begin
    v1_r      <= go;
    v2_r      <= v1_r;
    done      <= v2_r;
    if (go) begin
      neg_r     <= diff[34];
      mag_r     <= mag_c;
      ihi_r     <= inv[31:16];
      ilo_r     <= inv[15:0];
      quarter_r <= quarter;
    end
    a_r        <= mag_r * ihi_r;
    b_r        <= mag_r * ilo_r;
    neg2_r     <= neg_r;
    quarter2_r <= quarter_r;
    res_r      <= fin_c[31:0];
  end

  always_comb begin
    q_c    = {1'b0, a_r} + 51'(b_r[49:16]);
    quot_c = quarter2_r ? (q_c >> 2) : q_c;
    rem_c  = (b_r[15:0] != 16'd0) || (quarter2_r && (q_c[1:0] != 2'd0));
    if (neg2_r && rem_c) quot_c = quot_c + 51'd1;
    if (neg2_r) begin
      if (quot_c >= 51'h80000000) fin_c = 51'h80000000;
      else                        fin_c = 51'(-quot_c);
    end else begin
      if (quot_c > 51'h7FFFFFFF)  fin_c = 51'h7FFFFFFF;
      else                        fin_c = quot_c;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ===== rtl/core/staggered_grid_velocity_gradient.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// staggered_grid_velocity_gradient
// three face velocity stores and a sequenced stencil that gives the gradient
// ----------------------------------------------------------------------------
// channel  ports                         handshake
// input    in_kind/pos_*/sample          start & !busy
// result   out_d*, out_bad_cell          out_strobe, one cycle
// config   cfg_we, cfg_index, cfg_data   cfg_we
// a load is written on accept and leaves busy low. a compute item reads 30
// stencil samples (12 in 2D) through the single read port of the stores, one
// a cycle, then issues the nine entries one a cycle into a three-stage
// multiplier unit; strobe in the last busy cycle. a bad cell skips to the
// strobe. synchronous reset clears control and configuration registers; the
// stores and datapath are not cleared. results cannot be stalled.
module staggered_grid_velocity_gradient (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_kind,
  input  wire logic [4:0]  in_pos_x,
  input  wire logic [4:0]  in_pos_y,
  input  wire logic [4:0]  in_pos_z,
  input  wire logic signed [31:0] in_sample,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic             out_strobe,
  output logic signed [31:0] out_dudx,
  output logic signed [31:0] out_dudy,
  output logic signed [31:0] out_dudz,
  output logic signed [31:0] out_dvdx,
  output logic signed [31:0] out_dvdy,
  output logic signed [31:0] out_dvdz,
  output logic signed [31:0] out_dwdx,
  output logic signed [31:0] out_dwdy,
  output logic signed [31:0] out_dwdz,
  output logic             out_bad_cell
);
  import sgvg_pkg::*;

  // configuration registers
  logic [4:0]  cx_r, cy_r, cz_r;
  logic        flat_r;
  logic [31:0] ix_r, iy_r, iz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= 5'd16; cy_r <= 5'd16; cz_r <= 5'd16; flat_r <= 1'b0;
      ix_r <= 32'd65536; iy_r <= 32'd65536; iz_r <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CX:  cx_r   <= cfg_data[4:0];
        REG_CY:  cy_r   <= cfg_data[4:0];
        REG_CZ:  cz_r   <= cfg_data[4:0];
        REG_FL:  flat_r <= cfg_data[0];
        REG_IX:  ix_r   <= cfg_data;
        REG_IY:  iy_r   <= cfg_data;
        REG_IZ:  iz_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // stores
  logic [31:0] u_mem [DEPTH];
  logic [31:0] v_mem [DEPTH];
  logic [31:0] w_mem [DEPTH];

  logic        accept;
  logic        is_load, load_in;
  logic [AW-1:0] waddr;
  assign accept  = start && !busy;
  assign is_load = in_kind != KIND_C;
  assign load_in = (32'(in_pos_x) < SX) && (32'(in_pos_y) < SY) && (32'(in_pos_z) < SZ);
  assign waddr   = AW'((32'(in_pos_z) * SY + 32'(in_pos_y)) * SX + 32'(in_pos_x));

  // state
  state_t st_r, st_nxt;
  logic [SW-1:0] step_r;
  logic [4:0]  bx_r, by_r, bz_r;
  logic        bad_r;
  logic        rv_r;
  tap_t        rtap_r;
  logic signed [34:0] acc_r [9];
  logic [31:0] g_r [9];
  logic [3:0]  sent_r, got_r;

  // bad cell check
  logic [4:0] ex, ey, ez;
  logic       bad_c;
  assign ex = (cx_r > 5'(MAX_CELLS_X)) ? 5'(MAX_CELLS_X) : cx_r;
  assign ey = (cy_r > 5'(MAX_CELLS_Y)) ? 5'(MAX_CELLS_Y) : cy_r;
  assign ez = (cz_r > 5'(MAX_CELLS_Z)) ? 5'(MAX_CELLS_Z) : cz_r;
  assign bad_c = (in_pos_x >= ex) || (in_pos_y >= ey) ||
                 (flat_r ? (in_pos_z != 5'd0) : (in_pos_z >= ez));

  // read address of the current tap
  tap_t        tap_c;
  logic [6:0]  rx, ry, rz;
  logic        rin_c;
  logic [AW-1:0] raddr;
  logic [SW-1:0] last_step;
  assign tap_c = tap_of(step_r);
  assign last_step = flat_r ? SW'(11) : SW'(NREAD - 1);
  assign rx = 7'(bx_r) + 7'(GHOST) + 7'(tap_c.dx) - 7'd1;
  assign ry = 7'(by_r) + 7'(GHOST) + 7'(tap_c.dy) - 7'd1;
  assign rz = flat_r ? 7'(tap_c.dz) - 7'd1 : 7'(bz_r) + 7'(GHOST) + 7'(tap_c.dz) - 7'd1;
  assign rin_c = (32'(rx) < SX) && (32'(ry) < SY) && (32'(rz) < SZ);
  assign raddr = AW'((32'(rz) * SY + 32'(ry)) * SX + 32'(rx));

  logic [31:0] ru_r, rvv_r, rw_r;
  logic        rok_r;
  logic        rd_en;
  assign rd_en = (st_r == ST_READ);

  // store write and read ports
  always_ff @(posedge clk) begin
    if (accept && is_load && load_in) begin
      unique case (in_kind)
        KIND_U:  u_mem[waddr] <= in_sample;
        KIND_V:  v_mem[waddr] <= in_sample;
        default: w_mem[waddr] <= in_sample;
      endcase
    end
    if (rd_en) begin
      ru_r  <= u_mem[raddr];
      rvv_r <= v_mem[raddr];
      rw_r  <= w_mem[raddr];
    end
  end

  // selected sample of the registered read
  logic signed [34:0] samp_c;
  always_comb begin
    logic [31:0] s;
    unique case (rtap_r.st)
      KIND_U:  s = ru_r;
      KIND_V:  s = rvv_r;
      default: s = rw_r;
    endcase
    samp_c = rok_r ? 35'(signed'(s)) : 35'sd0;
  end

  // scaling unit
  ent_t        ep_c;
  logic [31:0] inv_c;
  logic        sc_go, sc_done;
  logic [31:0] sc_res;
  assign ep_c = ent_of(sent_r);
  always_comb begin
    unique case (ep_c.axis)
      2'd0:    inv_c = ix_r;
      2'd1:    inv_c = iy_r;
      default: inv_c = iz_r;
    endcase
  end
  assign sc_go = (st_r == ST_SCALE) && (sent_r < 4'd9);

  sgvg_scale u_scale (
    .clk     (clk),
    .go      (sc_go),
    .diff    (acc_r[sent_r]),
    .inv     (inv_c),
    .quarter (ep_c.quarter),
    .done    (sc_done),
    .res     (sc_res)
  );

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (accept && !is_load) st_nxt = bad_c ? ST_DONE : ST_READ;
      ST_READ:  if (step_r == last_step) st_nxt = ST_SCALE;
      ST_SCALE: if (got_r == 4'd9) st_nxt = ST_DONE;
      ST_DONE:  st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy       = (st_r != ST_IDLE);
    out_strobe = (st_r == ST_DONE);
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      step_r <= '0;
      rv_r   <= 1'b0;
      sent_r <= '0;
      got_r  <= '0;
      bad_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      rv_r <= rd_en;
      if (st_r == ST_IDLE && accept && !is_load) begin
        bx_r <= in_pos_x; by_r <= in_pos_y; bz_r <= in_pos_z;
        bad_r  <= bad_c;
        step_r <= '0;
        sent_r <= '0;
        got_r  <= '0;
        for (int k = 0; k < 9; k++) begin
          acc_r[k] <= '0;
          g_r[k]   <= '0;
        end
      end
      if (rd_en) begin
        rtap_r <= tap_c;
        rok_r  <= rin_c;
        step_r <= step_r + SW'(1);
      end
      // accumulate the registered sample into its entry
      if (rv_r) begin
        if (rtap_r.neg) acc_r[rtap_r.ent] <= acc_r[rtap_r.ent] - samp_c;
        else            acc_r[rtap_r.ent] <= acc_r[rtap_r.ent] + samp_c;
      end
      if (sc_go) sent_r <= sent_r + 4'd1;
      if (sc_done && got_r < 4'd9) begin
        g_r[got_r] <= (flat_r && ent_of(got_r).three_d) ? 32'd0 : sc_res;
        got_r      <= got_r + 4'd1;
      end
    end
  end

  assign out_dudx     = g_r[0];
  assign out_dudy     = g_r[1];
  assign out_dudz     = g_r[2];
  assign out_dvdx     = g_r[3];
  assign out_dvdy     = g_r[4];
  assign out_dvdz     = g_r[5];
  assign out_dwdx     = g_r[6];
  assign out_dwdy     = g_r[7];
  assign out_dwdz     = g_r[8];
  assign out_bad_cell = bad_r;

  // checks
  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("strobe longer than one cycle");
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_bad_cell) |-> (out_dudx == 0 && out_dvdy == 0))
    else $error("bad cell with nonzero result");
  a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && flat_r) |-> (out_dwdz == 0 && out_dudz == 0))
    else $error("flat mode with nonzero z entry");

endmodule
`default_nettype wire
